/* sv/jad_pkg.sv */
package jad_pkg;

    // Default build sizes.
    localparam int JAD_NUM_CPUS    = 8;
    localparam int JAD_QUEUE_DEPTH = 64;

    // Fixed field widths.
    localparam int TAG_W      = 16;
    localparam int CPU_IDX_W  = 3;
    localparam int STATUS_W   = 3;
    localparam int LOAD_W     = 8;
    localparam int MAX_RUN_W  = 8;
    localparam int WL_LIM_W   = 7;
    localparam int WORKLOAD_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [LOAD_W-1:0]     LOAD_MAX     = 8'd255;
    localparam logic [WORKLOAD_W-1:0] WORKLOAD_MAX = 9'd511;

    // Configuration reset values.
    localparam logic [MAX_RUN_W-1:0] MAX_RUN_RST = 8'd4;
    localparam logic [WL_LIM_W-1:0]  WL_LIM_RST  = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_RUNNING    = 1'b0,
        REG_WAITLIST_LIMIT = 1'b1
    } t_cfg_reg;

    typedef enum logic [0:0] {
        REQ_SUBMIT = 1'b0,
        REQ_FINISH = 1'b1
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_STARTED    = 3'd0,
        ST_WAITLISTED = 3'd1,
        ST_REJECTED   = 3'd2,
        ST_COMPLETED  = 3'd3,
        ST_IGNORED    = 3'd4
    } t_status;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // latch a new request and restart the load scan
        logic scan;     // examine one processor
        logic commit;   // apply the request and fill the output register
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic scan_last;
    } t_dp_stat;

endpackage

/* sv/jad_ctrl.sv */
module jad_ctrl
    import jad_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // The result can only be written once the output register is free.
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* sv/jad_dpath.sv */
module jad_dpath
    import jad_pkg::*;
#(
    parameter int NUM_CPUS    = JAD_NUM_CPUS,
    parameter int QUEUE_DEPTH = JAD_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_req_type,
    input  logic [TAG_W-1:0]      i_job_tag,
    input  logic [CPU_IDX_W-1:0]  i_cpu_index,
    output logic [STATUS_W-1:0]   o_status,
    output logic                  o_dispatch_valid,
    output logic [TAG_W-1:0]      o_dispatch_tag,
    output logic [CPU_IDX_W-1:0]  o_dispatch_cpu,
    output logic                  o_busy_res,
    output logic [WORKLOAD_W-1:0] o_workload
);

    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int CMP_W  = (CPU_W > CPU_IDX_W) ? CPU_W : CPU_IDX_W;
    localparam int Q_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CAP_W  = (FILL_W > WL_LIM_W) ? FILL_W : WL_LIM_W;
    localparam int SUM_W  = ((FILL_W > MAX_RUN_W) ? FILL_W : MAX_RUN_W) + 1;

    localparam logic [CPU_W-1:0] LAST_CPU = CPU_W'(NUM_CPUS - 1);
    localparam logic [Q_W-1:0]   LAST_Q   = Q_W'(QUEUE_DEPTH - 1);

    // Configuration.
    logic [MAX_RUN_W-1:0] r_max_run;
    logic [WL_LIM_W-1:0]  r_wl_limit;

    // Scheduler state.
    logic [MAX_RUN_W-1:0] r_running, n_running;
    logic [LOAD_W-1:0]    r_cpu_load [NUM_CPUS];
    logic [LOAD_W-1:0]    n_cpu_load [NUM_CPUS];
    logic [Q_W-1:0]       r_head, n_head;
    logic [Q_W-1:0]       r_tail, n_tail;
    logic [FILL_W-1:0]    r_fill, n_fill;
    logic [TAG_W-1:0]     r_mem [QUEUE_DEPTH];
    logic [TAG_W-1:0]     r_rd_data;

    // Latched request.
    t_req                 r_req;
    logic [TAG_W-1:0]     r_tag;
    logic [CPU_IDX_W-1:0] r_cpu;

    // Load scan.
    logic [CPU_W-1:0]  r_scan_idx;
    logic [CPU_W-1:0]  r_best_idx;
    logic [LOAD_W-1:0] r_best_load;
    logic              r_cpl_ok;
    logic [LOAD_W-1:0] scan_load;
    logic [LOAD_W-1:0] scan_eff;
    logic              scan_hit;
    logic              scan_dec;

    // Output register.
    t_status                r_status;
    logic                   r_dv;
    logic [TAG_W-1:0]       r_dtag;
    logic [CPU_IDX_W-1:0]   r_dcpu;
    logic                   r_busy;
    logic [WORKLOAD_W-1:0]  r_workload;

    // Commit decision.
    t_status            cm_status;
    logic               cm_push;
    logic               cm_pop;
    logic               cm_disp;
    logic               cm_dec;
    logic [TAG_W-1:0]   cm_tag;
    logic               slot_free;
    logic               wl_full;
    logic [CAP_W-1:0]   wl_cap;
    logic [MAX_RUN_W-1:0] run_dec;
    logic [SUM_W-1:0]   work_sum;
    logic [WORKLOAD_W-1:0] n_workload;
    logic               n_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_run  <= MAX_RUN_RST;
            r_wl_limit <= WL_LIM_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_MAX_RUNNING:    r_max_run  <= i_cfg_data[MAX_RUN_W-1:0];
                REG_WAITLIST_LIMIT: r_wl_limit <= i_cfg_data[WL_LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // The finishing processor counts one less while the minimum is searched,
    // since its job leaves before the waitlist head is placed.
    assign scan_load = r_cpu_load[r_scan_idx];
    assign scan_hit  = (CMP_W'(r_scan_idx) == CMP_W'(r_cpu));
    assign scan_dec  = (r_req == REQ_FINISH) && scan_hit && (scan_load != '0);
    assign scan_eff  = scan_load - LOAD_W'(scan_dec);

    assign o_stat.scan_last = (r_scan_idx == LAST_CPU);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req      <= t_req'(i_req_type);
            r_tag      <= i_job_tag;
            r_cpu      <= i_cpu_index;
            r_scan_idx <= '0;
            r_cpl_ok   <= 1'b0;
        end else if (i_cmd.scan) begin
            if (r_scan_idx == '0 || scan_eff < r_best_load) begin
                r_best_idx  <= r_scan_idx;
                r_best_load <= scan_eff;
            end
            if (scan_dec) begin
                r_cpl_ok <= 1'b1;
            end
            if (r_scan_idx != LAST_CPU) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
        end
    end

    assign wl_cap    = (CAP_W'(r_wl_limit) < CAP_W'(QUEUE_DEPTH))
                       ? CAP_W'(r_wl_limit) : CAP_W'(QUEUE_DEPTH);
    assign wl_full   = (CAP_W'(r_fill) >= wl_cap);
    assign slot_free = (r_running < r_max_run);

    always_comb begin
        cm_status = ST_IGNORED;
        cm_push   = 1'b0;
        cm_pop    = 1'b0;
        cm_disp   = 1'b0;
        cm_dec    = 1'b0;
        cm_tag    = r_tag;
        if (r_req == REQ_SUBMIT) begin
            if (!slot_free) begin
                if (wl_full) begin
                    cm_status = ST_REJECTED;
                end else begin
                    cm_push   = 1'b1;
                    cm_status = ST_WAITLISTED;
                end
            end else begin
                cm_disp   = 1'b1;
                cm_status = ST_STARTED;
                // Waiting jobs go first; the new one joins the tail.
                if (r_fill != '0) begin
                    cm_tag  = r_rd_data;
                    cm_pop  = 1'b1;
                    cm_push = 1'b1;
                end
            end
        end else if (r_cpl_ok) begin
            cm_dec    = 1'b1;
            cm_status = ST_COMPLETED;
            if (r_fill != '0) begin
                cm_tag  = r_rd_data;
                cm_pop  = 1'b1;
                cm_disp = 1'b1;
            end
        end
    end

    always_comb begin
        run_dec = (cm_dec && r_running != '0) ? r_running - 1'b1 : r_running;
        n_running = (cm_disp && run_dec != LOAD_MAX) ? run_dec + 1'b1 : run_dec;

        n_fill = r_fill;
        if (cm_push && !cm_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (cm_pop && !cm_push) begin
            n_fill = r_fill - 1'b1;
        end

        n_head = r_head;
        if (cm_pop) begin
            n_head = (r_head == LAST_Q) ? '0 : r_head + 1'b1;
        end
        n_tail = r_tail;
        if (cm_push) begin
            n_tail = (r_tail == LAST_Q) ? '0 : r_tail + 1'b1;
        end

        work_sum   = SUM_W'(n_fill) + SUM_W'(n_running);
        n_workload = (work_sum > SUM_W'(WORKLOAD_MAX)) ? WORKLOAD_MAX
                                                       : work_sum[WORKLOAD_W-1:0];
        n_busy     = (CAP_W'(n_fill) >= wl_cap) && (n_running >= r_max_run);
    end

    // Each processor's count changes on its own: one less when its job
    // finished, one more when it receives the dispatched job.
    always_comb begin
        for (int i = 0; i < NUM_CPUS; i++) begin
            n_cpu_load[i] = r_cpu_load[i];
            if (cm_dec && CMP_W'(i) == CMP_W'(r_cpu)) begin
                n_cpu_load[i] = n_cpu_load[i] - 1'b1;
            end
            if (cm_disp && CPU_W'(i) == r_best_idx && n_cpu_load[i] != LOAD_MAX) begin
                n_cpu_load[i] = n_cpu_load[i] + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_fill    <= '0;
            for (int i = 0; i < NUM_CPUS; i++) begin
                r_cpu_load[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            r_running <= n_running;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_fill    <= n_fill;
            for (int i = 0; i < NUM_CPUS; i++) begin
                r_cpu_load[i] <= n_cpu_load[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && cm_push) begin
            r_mem[r_tail] <= r_tag;
        end
        r_rd_data <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status   <= cm_status;
            r_dv       <= cm_disp;
            r_dtag     <= cm_disp ? cm_tag : '0;
            r_dcpu     <= cm_disp ? CPU_IDX_W'(r_best_idx) : '0;
            r_busy     <= n_busy;
            r_workload <= n_workload;
        end
    end

    assign o_status         = r_status;
    assign o_dispatch_valid = r_dv;
    assign o_dispatch_tag   = r_dtag;
    assign o_dispatch_cpu   = r_dcpu;
    assign o_busy_res       = r_busy;
    assign o_workload       = r_workload;

endmodule

/* sv/job_admission_dispatcher.sv */
// Channel   | Handshake                   | Payload
// ----------+-----------------------------+-----------------------------------------
// request   | i_in_valid / o_in_stall     | i_req_type, i_job_tag, i_cpu_index
// result    | o_out_valid / i_out_stall   | o_status, o_dispatch_valid, o_dispatch_tag,
//           |                             | o_dispatch_cpu, o_busy_res, o_workload
// config    | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// Each request is accepted, then the least-loaded scan looks at the processors one at
// a time, and a commit step updates the counters and the waitlist.
// The result sits in an output register, so a new request is taken while it waits.
// A stalled result holds the commit step until the output register frees up.
// Reset is synchronous and clears counters and pointers.
module job_admission_dispatcher
    import jad_pkg::*;
#(
    parameter int NUM_CPUS    = JAD_NUM_CPUS,
    parameter int QUEUE_DEPTH = JAD_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic [TAG_W-1:0]      i_job_tag,
    input  logic [CPU_IDX_W-1:0]  i_cpu_index,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STATUS_W-1:0]   o_status,
    output logic                  o_dispatch_valid,
    output logic [TAG_W-1:0]      o_dispatch_tag,
    output logic [CPU_IDX_W-1:0]  o_dispatch_cpu,
    output logic                  o_busy_res,
    output logic [WORKLOAD_W-1:0] o_workload,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    jad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    jad_dpath #(
        .NUM_CPUS    (NUM_CPUS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_req_type       (i_req_type),
        .i_job_tag        (i_job_tag),
        .i_cpu_index      (i_cpu_index),
        .o_status         (o_status),
        .o_dispatch_valid (o_dispatch_valid),
        .o_dispatch_tag   (o_dispatch_tag),
        .o_dispatch_cpu   (o_dispatch_cpu),
        .o_busy_res       (o_busy_res),
        .o_workload       (o_workload)
    );

endmodule

/* tb/dispatch_checker.sv */
`timescale 1ns / 1ps

module dispatch_checker
    import jad_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_stall,
    input  logic                  i_req_type,
    input  logic [TAG_W-1:0]      i_job_tag,
    input  logic [CPU_IDX_W-1:0]  i_cpu_index,
    input  logic                  i_res_valid,
    input  logic                  i_res_stall,
    input  logic [STATUS_W-1:0]   i_status,
    input  logic                  i_dispatch_valid,
    input  logic [TAG_W-1:0]      i_dispatch_tag,
    input  logic [CPU_IDX_W-1:0]  i_dispatch_cpu,
    input  logic                  i_busy_res,
    input  logic [WORKLOAD_W-1:0] i_workload,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int PTR_W = $clog2(JAD_QUEUE_DEPTH);

    typedef struct {
        t_status                status;
        logic                   dispatched;
        logic [TAG_W-1:0]       tag;
        logic [CPU_IDX_W-1:0]   cpu;
        logic                   busy;
        logic [WORKLOAD_W-1:0]  workload;
    } t_dispatch_outcome;

    // Shadow copy of the admission state and its two registers.
    logic [MAX_RUN_W-1:0] max_run;
    logic [WL_LIM_W-1:0]  wl_lim;
    logic [LOAD_W-1:0]    running;
    logic [LOAD_W-1:0]    cpu_load [JAD_NUM_CPUS];
    logic [TAG_W-1:0]     waitlist [JAD_QUEUE_DEPTH];
    logic [PTR_W-1:0]     wl_head;
    logic [PTR_W-1:0]     wl_tail;
    logic [PTR_W:0]       wl_fill;

    t_dispatch_outcome outcomes_due [$];
    t_dispatch_outcome oldest;

    task automatic log_failure(input string msg);
        o_fail_count++;
        $display("checker: %s", msg);
    endtask

    function automatic int waitlist_room();
        return (wl_lim < JAD_QUEUE_DEPTH) ? int'(wl_lim) : JAD_QUEUE_DEPTH;
    endfunction

    function automatic void waitlist_push(input logic [TAG_W-1:0] tag);
        waitlist[wl_tail] = tag;
        wl_tail = wl_tail + 1'b1;
        wl_fill = wl_fill + 1'b1;
    endfunction

    function automatic logic [TAG_W-1:0] waitlist_pop();
        logic [TAG_W-1:0] tag;
        tag = waitlist[wl_head];
        wl_head = wl_head + 1'b1;
        wl_fill = wl_fill - 1'b1;
        return tag;
    endfunction

    // Least loaded processor wins, the lowest index on a tie.
    function automatic logic [CPU_IDX_W-1:0] place_on_least_loaded();
        logic [CPU_IDX_W-1:0] best;
        int c;
        best = '0;
        for (c = 1; c < JAD_NUM_CPUS; c++) begin
            if (cpu_load[CPU_IDX_W'(c)] < cpu_load[best]) begin
                best = CPU_IDX_W'(c);
            end
        end
        if (cpu_load[best] != LOAD_MAX) begin
            cpu_load[best]++;
        end
        if (running != LOAD_MAX) begin
            running++;
        end
        return best;
    endfunction

    function automatic t_dispatch_outcome predict_outcome(
        input t_req                 rq,
        input logic [TAG_W-1:0]     tag,
        input logic [CPU_IDX_W-1:0] cpu
    );
        t_dispatch_outcome o;
        int work;
        o.status     = ST_IGNORED;
        o.dispatched = 1'b0;
        o.tag        = '0;
        o.cpu        = '0;
        if (rq == REQ_SUBMIT) begin
            if (running >= max_run) begin
                if (wl_fill >= waitlist_room()) begin
                    o.status = ST_REJECTED;
                end else begin
                    waitlist_push(tag);
                    o.status = ST_WAITLISTED;
                end
            end else begin
                // A free slot serves the waitlist head before the new job.
                if (wl_fill == 0) begin
                    o.tag = tag;
                end else begin
                    o.tag = waitlist_pop();
                    waitlist_push(tag);
                end
                o.cpu        = place_on_least_loaded();
                o.dispatched = 1'b1;
                o.status     = ST_STARTED;
            end
        end else if (int'(cpu) >= JAD_NUM_CPUS || cpu_load[cpu] == 0) begin
            o.status = ST_IGNORED;
        end else begin
            cpu_load[cpu]--;
            if (running != 0) begin
                running--;
            end
            // The freed slot goes to the waitlist head regardless of max_running.
            if (wl_fill != 0) begin
                o.tag        = waitlist_pop();
                o.cpu        = place_on_least_loaded();
                o.dispatched = 1'b1;
            end
            o.status = ST_COMPLETED;
        end
        work = wl_fill + running;
        if (work > WORKLOAD_MAX) begin
            work = WORKLOAD_MAX;
        end
        o.workload = work[WORKLOAD_W-1:0];
        o.busy     = (wl_fill >= waitlist_room()) && (running >= max_run);
        return o;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_run = MAX_RUN_RST;
            wl_lim  = WL_LIM_RST;
            running = '0;
            foreach (cpu_load[c]) begin
                cpu_load[c] = '0;
            end
            wl_head = '0;
            wl_tail = '0;
            wl_fill = '0;
            outcomes_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_MAX_RUNNING: begin
                        max_run = i_cfg_data[MAX_RUN_W-1:0];
                    end
                    REG_WAITLIST_LIMIT: begin
                        wl_lim = i_cfg_data[WL_LIM_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_req_valid && !i_req_stall) begin
                outcomes_due.push_back(predict_outcome(t_req'(i_req_type), i_job_tag,
                                                       i_cpu_index));
            end
            if (i_res_valid && !i_res_stall) begin
                if (outcomes_due.size() == 0) begin
                    log_failure($sformatf("result with status %0d and nothing pending",
                                          i_status));
                end else begin
                    oldest = outcomes_due.pop_front();
                    if (i_status !== oldest.status) begin
                        log_failure($sformatf("status: expected %0d, got %0d",
                                              oldest.status, i_status));
                    end
                    if (i_dispatch_valid !== oldest.dispatched) begin
                        log_failure($sformatf("dispatch_valid: expected %0d, got %0d",
                                              oldest.dispatched, i_dispatch_valid));
                    end
                    if (i_dispatch_tag !== oldest.tag) begin
                        log_failure($sformatf("dispatch_tag: expected %h, got %h",
                                              oldest.tag, i_dispatch_tag));
                    end
                    if (i_dispatch_cpu !== oldest.cpu) begin
                        log_failure($sformatf("dispatch_cpu: expected %0d, got %0d",
                                              oldest.cpu, i_dispatch_cpu));
                    end
                    if (i_busy_res !== oldest.busy) begin
                        log_failure($sformatf("busy_res: expected %0d, got %0d",
                                              oldest.busy, i_busy_res));
                    end
                    if (i_workload !== oldest.workload) begin
                        log_failure($sformatf("workload: expected %0d, got %0d",
                                              oldest.workload, i_workload));
                    end
                end
            end
        end
        o_pending = outcomes_due.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import jad_pkg::*;

    localparam int ITEM_CYCLES = JAD_NUM_CPUS + 2;
    localparam int SETTLE      = 2 * ITEM_CYCLES;
    localparam int CYCLE_LIMIT = 600000;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_kind;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_req_type  = 1'b0;
    logic [TAG_W-1:0]      i_job_tag   = '0;
    logic [CPU_IDX_W-1:0]  i_cpu_index = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [STATUS_W-1:0]   o_status;
    logic                  o_dispatch_valid;
    logic [TAG_W-1:0]      o_dispatch_tag;
    logic [CPU_IDX_W-1:0]  o_dispatch_cpu;
    logic                  o_busy_res;
    logic [WORKLOAD_W-1:0] o_workload;
    logic                  o_cfg_ready;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          burst_left  = 0;
    t_stall_kind stall_mode  = STALL_NONE;
    int          stall_span  = 0;

    job_admission_dispatcher i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_job_tag        (i_job_tag),
        .i_cpu_index      (i_cpu_index),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_dispatch_valid (o_dispatch_valid),
        .o_dispatch_tag   (o_dispatch_tag),
        .o_dispatch_cpu   (o_dispatch_cpu),
        .o_busy_res       (o_busy_res),
        .o_workload       (o_workload),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    dispatch_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_in_valid),
        .i_req_stall      (o_in_stall),
        .i_req_type       (i_req_type),
        .i_job_tag        (i_job_tag),
        .i_cpu_index      (i_cpu_index),
        .i_res_valid      (o_out_valid),
        .i_res_stall      (i_out_stall),
        .i_status         (o_status),
        .i_dispatch_valid (o_dispatch_valid),
        .i_dispatch_tag   (o_dispatch_tag),
        .i_dispatch_cpu   (o_dispatch_cpu),
        .i_busy_res       (o_busy_res),
        .i_workload       (o_workload),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // The result side switches between stall behaviors over spans of random length.
    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= t_stall_kind'($urandom_range(0, 3));
            stall_span <= $urandom_range(8, 120);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            STALL_NONE: begin
                i_out_stall <= 1'b0;
            end
            STALL_LIGHT: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            STALL_HEAVY: begin
                i_out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_out_stall <= ~i_out_stall;
            end
        endcase
    end

    // Called at a falling edge; returns at the falling edge after the transaction
    // with valid still high, so the caller either sends again or drops it.
    task automatic send_request(input t_req rq, input logic [TAG_W-1:0] tag,
                                input logic [CPU_IDX_W-1:0] cpu);
        i_in_valid  <= 1'b1;
        i_req_type  <= rq;
        i_job_tag   <= tag;
        i_cpu_index <= cpu;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_register(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int submit_pct);
        int n;
        int gap;
        t_req rq;
        for (n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                if (gap != 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            burst_left--;
            rq = ($urandom_range(0, 99) < submit_pct) ? REQ_SUBMIT : REQ_FINISH;
            send_request(rq, TAG_W'($urandom), CPU_IDX_W'($urandom_range(0, 7)));
        end
    endtask

    initial begin
        int phase;
        logic [CFG_DATA_W-1:0] run_limit;
        logic [CFG_DATA_W-1:0] wl_data;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Completions with nothing running are ignored.
        send_request(REQ_FINISH, TAG_W'($urandom), 3'd0);
        send_request(REQ_FINISH, TAG_W'($urandom), 3'd7);
        // Fill the four default slots, then one waits.
        send_request(REQ_SUBMIT, 16'h0000, CPU_IDX_W'($urandom));
        send_request(REQ_SUBMIT, 16'hFFFF, CPU_IDX_W'($urandom));
        send_request(REQ_SUBMIT, 16'hA5A5, CPU_IDX_W'($urandom));
        send_request(REQ_SUBMIT, 16'h5A5A, CPU_IDX_W'($urandom));
        send_request(REQ_SUBMIT, 16'h1234, CPU_IDX_W'($urandom));
        send_request(REQ_FINISH, TAG_W'($urandom), 3'd2);
        send_request(REQ_FINISH, TAG_W'($urandom), 3'd5);
        send_request(REQ_SUBMIT, 16'h8001, CPU_IDX_W'($urandom));
        // A free slot with a waiting job: the head starts, the new job queues.
        write_register(REG_MAX_RUNNING, 8'd6);
        send_request(REQ_SUBMIT, 16'h7FFE, CPU_IDX_W'($urandom));
        // Limit below the running count; a completion still dispatches the head.
        write_register(REG_MAX_RUNNING, 8'd1);
        send_request(REQ_SUBMIT, 16'h0F0F, CPU_IDX_W'($urandom));
        send_request(REQ_FINISH, TAG_W'($urandom), 3'd0);
        write_register(REG_MAX_RUNNING, 8'd0);
        write_register(REG_WAITLIST_LIMIT, 8'd2);
        send_request(REQ_SUBMIT, 16'hF0F0, CPU_IDX_W'($urandom));
        write_register(REG_WAITLIST_LIMIT, 8'd0);
        send_request(REQ_SUBMIT, 16'h3C3C, CPU_IDX_W'($urandom));
        // The upper data bit is dropped and the capacity clips to the FIFO depth.
        write_register(REG_WAITLIST_LIMIT, 8'hFF);
        send_request(REQ_SUBMIT, 16'hC3C3, CPU_IDX_W'($urandom));
        write_register(REG_MAX_RUNNING, 8'd255);
        send_request(REQ_SUBMIT, 16'h0001, CPU_IDX_W'($urandom));
        send_request(REQ_FINISH, TAG_W'($urandom), 3'd5);
        send_request(REQ_FINISH, TAG_W'($urandom), 3'd6);
        send_request(REQ_FINISH, TAG_W'($urandom), 3'd1);
        send_request(REQ_SUBMIT, 16'h8000, CPU_IDX_W'($urandom));

        for (phase = 0; phase < 12; phase++) begin
            case (phase)
                0: begin
                    run_limit = 8'd255;
                    wl_data   = 8'd64;
                end
                1: begin
                    run_limit = 8'd1;
                    wl_data   = 8'd0;
                end
                2: begin
                    run_limit = 8'd0;
                    wl_data   = 8'hFF;
                end
                default: begin
                    run_limit = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 255))
                                                            : CFG_DATA_W'($urandom_range(0, 12));
                    wl_data   = ($urandom_range(0, 1) == 0) ? CFG_DATA_W'($urandom_range(0, 8))
                                                            : CFG_DATA_W'($urandom_range(0, 255));
                end
            endcase
            write_register(REG_MAX_RUNNING, run_limit);
            write_register(REG_WAITLIST_LIMIT, wl_data);
            if (phase == 0) begin
                run_phase(220, 85);
            end else begin
                run_phase(90, $urandom_range(35, 75));
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/jad_pkg.sv
sv/jad_ctrl.sv
sv/jad_dpath.sv
sv/job_admission_dispatcher.sv
tb/dispatch_checker.sv
tb/tb.sv
